>>> hw/rtl/cobs_dfr_pkg.sv
package cobs_dfr_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned STAT_W = 2;

  localparam logic [BYTE_W-1:0] DELIM_BYTE    = 8'h00;
  localparam logic [BYTE_W-1:0] MAX_CODE_BYTE = 8'hFF;
  localparam logic [LEN_W-1:0]  RESET_MAX_LEN = 16'd4096;

  typedef enum logic [STAT_W-1:0] {
    ST_DATA  = 2'd0,
    ST_VALID = 2'd1,
    ST_TRUNC = 2'd2,
    ST_LONG  = 2'd3
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] block_remaining;
    logic              zero_pending;
    logic [LEN_W-1:0]  encoded_count;
    logic              discarding;
  } frame_state_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    status_t           status;
    logic              frame_end;
  } result_t;

endpackage

>>> hw/rtl/cobs_dfr_step.sv
module cobs_dfr_step (
  input  cobs_dfr_pkg::frame_state_t        state_cur,
  input  logic [cobs_dfr_pkg::BYTE_W-1:0]   rx_byte,
  input  logic [cobs_dfr_pkg::LEN_W-1:0]    max_len,
  output cobs_dfr_pkg::frame_state_t        state_nxt,
  output cobs_dfr_pkg::result_t             result
);

  always_comb begin
    state_nxt        = state_cur;
    result.valid     = 1'b0;
    result.data      = '0;
    result.status    = cobs_dfr_pkg::ST_DATA;
    result.frame_end = 1'b0;

    if (rx_byte == cobs_dfr_pkg::DELIM_BYTE) begin
      state_nxt.block_remaining = '0;
      state_nxt.zero_pending    = 1'b0;
      state_nxt.encoded_count   = '0;
      state_nxt.discarding      = 1'b0;
      if (!state_cur.discarding && (state_cur.encoded_count != '0)) begin
        result.valid     = 1'b1;
        result.frame_end = 1'b1;
        result.status    = (state_cur.block_remaining == '0) ? cobs_dfr_pkg::ST_VALID
                                                             : cobs_dfr_pkg::ST_TRUNC;
      end
    end else if (state_cur.discarding) begin
      state_nxt = state_cur;
    end else if (state_cur.encoded_count >= max_len) begin
      // drop the rest of an oversized frame
      state_nxt.block_remaining = '0;
      state_nxt.zero_pending    = 1'b0;
      state_nxt.encoded_count   = '0;
      state_nxt.discarding      = 1'b1;
      result.valid              = 1'b1;
      result.frame_end          = 1'b1;
      result.status             = cobs_dfr_pkg::ST_LONG;
    end else begin
      state_nxt.encoded_count = state_cur.encoded_count + 1'b1;
      if (state_cur.block_remaining == '0) begin
        state_nxt.zero_pending    = (rx_byte != cobs_dfr_pkg::MAX_CODE_BYTE);
        state_nxt.block_remaining = rx_byte - 1'b1;
        result.valid              = state_cur.zero_pending;
      end else begin
        state_nxt.block_remaining = state_cur.block_remaining - 1'b1;
        result.valid              = 1'b1;
        result.data               = rx_byte;
      end
    end
  end

endmodule

>>> hw/rtl/cobs_stream_deframer_top.sv
// An accepted beat waits in the input register; its result goes to out_r.
// Throughput: one beat per cycle unless the output stalls; an input holding
//   register takes one more beat while a result waits on a stalled output.
// Reset (synchronous, rst_n low): frame state, discard flag and valids clear;
//   the length limit returns to 4096.
module cobs_stream_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_max_encoded_len,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_status,
  output logic        out_frame_end
);

  logic [cobs_dfr_pkg::LEN_W-1:0]  max_len_r;
  logic                            in_valid_r;
  logic [cobs_dfr_pkg::BYTE_W-1:0] in_byte_r;
  cobs_dfr_pkg::frame_state_t      state_r;
  cobs_dfr_pkg::frame_state_t      state_nxt;
  cobs_dfr_pkg::result_t           result;
  cobs_dfr_pkg::result_t           out_r;
  logic                            stage_stall;
  logic                            fire;

  assign stage_stall = out_r.valid && out_stall;
  assign fire        = in_valid_r && !stage_stall;
  assign in_stall    = in_valid_r && stage_stall;

  cobs_dfr_step u_step (
    .state_cur (state_r),
    .rx_byte   (in_byte_r),
    .max_len   (max_len_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= cobs_dfr_pkg::RESET_MAX_LEN;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_max_encoded_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (!stage_stall) begin
      out_r.valid <= fire && result.valid;
    end
    if (fire && result.valid) begin
      out_r.data      <= result.data;
      out_r.status    <= result.status;
      out_r.frame_end <= result.frame_end;
    end
  end

  assign out_valid     = out_r.valid;
  assign out_byte      = out_r.data;
  assign out_status    = out_r.status;
  assign out_frame_end = out_r.frame_end;

`ifndef SYNTHESIS
  a_end_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_r.valid |-> (out_r.frame_end == (out_r.status != cobs_dfr_pkg::ST_DATA)))
    else $error("frame_end disagrees with status");

  a_discard_clean: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.discarding |-> (state_r.encoded_count == '0 &&
                            state_r.block_remaining == '0 && !state_r.zero_pending))
    else $error("frame state not cleared while discarding");

  a_long_sets_discard: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && result.valid && result.status == cobs_dfr_pkg::ST_LONG)
      |=> state_r.discarding)
    else $error("too-long marker without discard");

  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && stage_stall) |=> in_valid_r)
    else $error("held input beat lost");
`endif

endmodule
